>>> sv/fcf_pkg.sv
// Shared constants and types for the fixed-length checksum framer.
`default_nettype none

package fcf_pkg;

   // Packet size register
   localparam int SIZE_W          = 7;
   localparam int MAX_PACKET_DEF  = 64;
   localparam int MIN_PACKET      = 3;
   localparam int CHECK_BYTES     = 2;
   localparam logic [SIZE_W-1:0] PACKET_SIZE_RESET = 7'd16;

   // Data widths
   localparam int BYTE_BITS = 8;
   localparam int SUM_W     = 16;
   localparam int COUNT_W   = 32;
   localparam int STEP_W    = $clog2(COUNT_W);

   // Divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } fcf_div_stat_type;

endpackage

`default_nettype wire

>>> sv/fcf_window.sv
// Circular byte store for the framing window, one write and one registered read port.
`default_nettype none

module fcf_window
   import fcf_pkg::*;
#(
   parameter int DEPTH = MAX_PACKET_DEF,
   parameter int AW    = $clog2(MAX_PACKET_DEF)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic [BYTE_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [AW-1:0]        rd_addr,
   output logic      [BYTE_BITS-1:0] rd_data
);

   logic [BYTE_BITS-1:0] mem [DEPTH];
   logic [BYTE_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/fcf_divider.sv
// Radix-2 restoring divider: 32-bit count by the packet size, one quotient bit per cycle.
`default_nettype none

module fcf_divider
   import fcf_pkg::*;
#(
   parameter int DIV_W = $clog2(MAX_PACKET_DEF + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [COUNT_W-1:0] dividend,
   input  wire logic [DIV_W-1:0]   divisor,
   output fcf_div_stat_type        stat,
   output logic      [COUNT_W-1:0] quotient
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [COUNT_W-1:0] quo_ff, quo_in;
   logic [DIV_W:0]     rem_sh;
   logic [DIV_W:0]     rem_diff;
   logic               q_bit;

   // one shift-subtract step
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[COUNT_W-1]};
      rem_diff = rem_sh - {1'b0, divisor};
      q_bit    = (rem_sh >= {1'b0, divisor});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = q_bit ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
         quo_in  = {quo_ff[COUNT_W-2:0], q_bit};
         step_in = STEP_W'(step_ff + STEP_W'(1));
         if (step_ff == STEP_W'(COUNT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

   // done only closes a running division
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

   // no restart while a division runs
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

`default_nettype wire

>>> sv/fixed_length_checksum_framer.sv
// Top level of the fixed-length checksum framer: sequencer, window store and divider.
//
// Usage: bytes from a serial link enter on the req_ stream, one per request.
// The block keeps a window of the last packet_size bytes. When the window is
// full it sums the payload bytes (16-bit wrapping) and compares the sum with
// the two trailing check bytes, high byte first. On a match the payload bytes
// leave on the rsp_ stream in arrival order, tlast on the final one, each with
// the dropped-packet count (skipped bytes / packet_size). On a mismatch the
// oldest byte is skipped and counted (saturating) and nothing is sent.
// Timing: a byte that fills the window starts a scan, one window read a cycle
// through a single adder; a match adds a bit-serial divide, then a window read
// and an output load per payload byte, held up while the receiver stalls.
// req_tready is low while a window is scanned, checked, divided or emitted,
// and while csr_valid is high.
// A stalled rsp_ holds its request; the byte read waits for the output register.
// Reset empties the window, clears the skipped count and sets packet_size to 16.
// csr_ writes (only taken while idle) set packet_size and empty the window.
`default_nettype none

module fixed_length_checksum_framer
   import fcf_pkg::*;
#(
   parameter int MAX_PACKET = MAX_PACKET_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request stream: [7:0] rx_byte
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [BYTE_BITS-1:0]          req_tdata,
   // response stream: [7:0] payload_byte, [39:8] dropped_packets
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [BYTE_BITS+COUNT_W-1:0]  rsp_tdata,
   output logic                               rsp_tlast,
   // packet size register write
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [SIZE_W-1:0]             csr_data
);

   localparam int AW = $clog2(MAX_PACKET);
   localparam int FW = $clog2(MAX_PACKET + 1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SCAN    = 3'd1;
   localparam logic [2:0] ST_CHECK   = 3'd2;
   localparam logic [2:0] ST_DIV     = 3'd3;
   localparam logic [2:0] ST_EMIT_RD = 3'd4;
   localparam logic [2:0] ST_EMIT_LD = 3'd5;

   // clamp a size write into the legal range
   function automatic logic [FW-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      logic [FW-1:0] r;
      if (v < SIZE_W'(MIN_PACKET)) begin
         r = FW'(MIN_PACKET);
      end else if (v > SIZE_W'(MAX_PACKET)) begin
         r = FW'(MAX_PACKET);
      end else begin
         r = v[FW-1:0];
      end
      return r;
   endfunction

   // circular address: head plus offset, wrapped once
   function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [FW-1:0] off);
      logic [AW+1:0] s;
      s = (AW+2)'(h) + (AW+2)'(off);
      if (s >= (AW+2)'(MAX_PACKET)) begin
         s = s - (AW+2)'(MAX_PACKET);
      end
      return s[AW-1:0];
   endfunction

   logic [2:0]                     state_ff, state_in;
   logic [FW-1:0]                  eff_ps_ff, eff_ps_in;
   logic [FW-1:0]                  fill_ff, fill_in;
   logic [AW-1:0]                  head_ff, head_in;
   logic [FW-1:0]                  cnt_ff, cnt_in;
   logic                           pend_ff, pend_in;
   logic [FW-1:0]                  pend_idx_ff, pend_idx_in;
   logic [SUM_W-1:0]               sum_ff, sum_in;
   logic [BYTE_BITS-1:0]           chk_hi_ff, chk_hi_in;
   logic [COUNT_W-1:0]             skipped_ff, skipped_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [BYTE_BITS+COUNT_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic [FW-1:0]                  plen;
   logic                           wr_en;
   logic                           rd_en;
   logic [AW-1:0]                  rd_addr;
   logic [BYTE_BITS-1:0]           rd_data;
   logic                           div_start;
   fcf_div_stat_type               div_stat;
   logic [COUNT_W-1:0]             div_q;
   logic                           req_acc;
   logic                           csr_acc;

   assign plen       = FW'(eff_ps_ff - FW'(CHECK_BYTES));
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_acc    = csr_valid && csr_ready;

   fcf_window #(
      .DEPTH (MAX_PACKET),
      .AW    (AW)
   ) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot(head_ff, fill_ff)),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fcf_divider #(
      .DIV_W (FW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (skipped_ff),
      .divisor  (eff_ps_ff),
      .stat     (div_stat),
      .quotient (div_q)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      eff_ps_in    = eff_ps_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      pend_idx_in  = cnt_ff;
      sum_in       = sum_ff;
      chk_hi_in    = chk_hi_ff;
      skipped_in   = skipped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = slot(head_ff, cnt_ff);
      div_start    = 1'b0;

      // window byte returning from the read issued last cycle
      if (pend_ff) begin
         if (pend_idx_ff < plen) begin
            sum_in = SUM_W'(sum_ff + SUM_W'(rd_data));
         end else if (pend_idx_ff == plen) begin
            chk_hi_in = rd_data;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_acc) begin
               eff_ps_in = clamp_size(csr_data);
               fill_in   = '0;
               head_in   = '0;
            end else if (req_acc) begin
               wr_en   = 1'b1;
               fill_in = FW'(fill_ff + FW'(1));
               if (FW'(fill_ff + FW'(1)) == eff_ps_ff) begin
                  state_in = ST_SCAN;
                  cnt_in   = '0;
                  sum_in   = '0;
               end
            end
         end
         ST_SCAN: begin
            rd_en   = 1'b1;
            pend_in = 1'b1;
            if (cnt_ff == FW'(eff_ps_ff - FW'(1))) begin
               state_in = ST_CHECK;
            end else begin
               cnt_in = FW'(cnt_ff + FW'(1));
            end
         end
         ST_CHECK: begin
            // low check byte arrives now
            if (sum_ff == {chk_hi_ff, rd_data}) begin
               div_start = 1'b1;
               cnt_in    = '0;
               state_in  = ST_DIV;
            end else begin
               head_in = slot(head_ff, FW'(1));
               fill_in = FW'(fill_ff - FW'(1));
               if (skipped_ff != '1) begin
                  skipped_in = skipped_ff + COUNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            rd_en    = 1'b1;
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {div_q, rd_data};
               rsp_last_in  = (cnt_ff == FW'(plen - FW'(1)));
               if (cnt_ff == FW'(plen - FW'(1))) begin
                  fill_in  = '0;
                  head_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  cnt_in   = FW'(cnt_ff + FW'(1));
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eff_ps_ff    <= clamp_size(PACKET_SIZE_RESET);
         fill_ff      <= '0;
         head_ff      <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         skipped_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eff_ps_ff    <= eff_ps_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         skipped_ff   <= skipped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      sum_ff      <= sum_in;
      chk_hi_ff   <= chk_hi_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // idle window is never full
   a_fill_below_size: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (fill_ff < eff_ps_ff))
      else $error("window full while idle");

   // skipped count never goes down
   a_skipped_monotone: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (skipped_ff >= $past(skipped_ff)))
      else $error("skipped count decreased");

   // emission uses a finished quotient
   a_emit_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_RD || state_ff == ST_EMIT_LD) |-> !div_stat.busy)
      else $error("emitting while divider busy");

endmodule

`default_nettype wire

>>> dv/fcf_checker.sv
// Response checker for the fixed-length checksum framer: window predictor and beat compare.
`timescale 1ns / 100ps

module fcf_checker
   import fcf_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   input  wire logic                         req_tready,
   input  wire logic [BYTE_BITS-1:0]         req_tdata,
   input  wire logic                         rsp_tvalid,
   input  wire logic                         rsp_tready,
   input  wire logic [BYTE_BITS+COUNT_W-1:0] rsp_tdata,
   input  wire logic                         rsp_tlast,
   input  wire logic                         csr_valid,
   input  wire logic                         csr_ready,
   input  wire logic [SIZE_W-1:0]            csr_data,
   output int                                mismatch_total,
   output int                                beats_pending
);

   // One payload byte of a validated packet as it should leave the block
   typedef struct packed {
      logic [BYTE_BITS-1:0] payload;
      logic                 last;
      logic [COUNT_W-1:0]   dropped;
   } payload_beat_type;

   logic [SIZE_W-1:0]    size_reg;
   logic [BYTE_BITS-1:0] window_q[$];
   logic [COUNT_W-1:0]   skip_count;
   payload_beat_type     payload_due[$];
   int                   errors = 0;

   // Register value clamped to the legal packet length
   function automatic int unsigned size_in_force();
      if (size_reg < MIN_PACKET) return MIN_PACKET;
      if (size_reg > MAX_PACKET_DEF) return MAX_PACKET_DEF;
      return size_reg;
   endfunction

   // Slide one byte into the window; queue the payload beats on a checksum hit
   function automatic void absorb_rx_byte(input logic [BYTE_BITS-1:0] rx);
      int unsigned          ps;
      int unsigned          plen;
      logic [SUM_W-1:0]     sum;
      logic [SUM_W-1:0]     check;
      payload_beat_type     beat;
      ps   = size_in_force();
      plen = ps - CHECK_BYTES;
      if (window_q.size() >= ps) window_q.delete();
      window_q.push_back(rx);
      if (window_q.size() < ps) return;

      sum = '0;
      for (int unsigned i = 0; i < plen; i++) sum = sum + window_q[i];
      check = {window_q[plen], window_q[plen+1]};

      // miss: oldest byte goes, skip count saturates
      if (sum != check) begin
         void'(window_q.pop_front());
         if (skip_count != '1) skip_count = skip_count + 1;
         return;
      end

      for (int unsigned i = 0; i < plen; i++) begin
         beat.payload = window_q[i];
         beat.last    = (i + 1 == plen);
         beat.dropped = skip_count / ps;
         payload_due.push_back(beat);
      end
      window_q.delete();
   endfunction

   // Watch all three channels at each edge
   always @(posedge clock) begin : monitor
      payload_beat_type want;
      if (reset) begin
         size_reg   = PACKET_SIZE_RESET;
         skip_count = '0;
         window_q.delete();
         payload_due.delete();
      end else begin
         // size write empties the window, keeps the skip count
         if (csr_valid && csr_ready) begin
            size_reg = csr_data;
            window_q.delete();
         end

         if (rsp_tvalid && rsp_tready) begin
            if (payload_due.size() == 0) begin
               errors++;
               $display("%0t: response with none expected, payload %02h last %0b dropped %0d",
                        $time, rsp_tdata[BYTE_BITS-1:0], rsp_tlast,
                        rsp_tdata[BYTE_BITS +: COUNT_W]);
            end else begin
               want = payload_due.pop_front();
               if (rsp_tdata[BYTE_BITS-1:0] !== want.payload) begin
                  errors++;
                  $display("%0t: payload_byte expected %02h got %02h",
                           $time, want.payload, rsp_tdata[BYTE_BITS-1:0]);
               end
               if (rsp_tlast !== want.last) begin
                  errors++;
                  $display("%0t: last_of_packet expected %0b got %0b",
                           $time, want.last, rsp_tlast);
               end
               if (rsp_tdata[BYTE_BITS +: COUNT_W] !== want.dropped) begin
                  errors++;
                  $display("%0t: dropped_packets expected %0d got %0d",
                           $time, want.dropped, rsp_tdata[BYTE_BITS +: COUNT_W]);
               end
            end
         end

         if (req_tvalid && req_tready) absorb_rx_byte(req_tdata);
      end
      mismatch_total <= errors;
      beats_pending  <= payload_due.size();
   end

endmodule

>>> dv/testbench.sv
// Testbench top for the fixed-length checksum framer: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module testbench
   import fcf_pkg::*;
();

   localparam int          CLOCK_PERIOD  = 10;
   localparam int          RESET_CYCLES  = 6;
   localparam int          SETTLE_CYCLES = 2 * MAX_PACKET_DEF + 40;
   localparam int          LONG_HOLD     = 500;
   localparam int          HOLD_AFTER    = 60;
   // far beyond the slowest legal run: every byte a full scan, divide and stalled emit
   localparam int unsigned CYCLE_LIMIT   = 1_500_000;

   typedef enum int {GOOD_FRAME, BAD_FRAME, NOISE_RUN} stream_kind_type;
   typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_type;

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [BYTE_BITS-1:0]         req_tdata  = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [BYTE_BITS+COUNT_W-1:0] rsp_tdata;
   logic                         rsp_tlast;
   logic                         csr_valid  = 1'b0;
   logic                         csr_ready;
   logic [SIZE_W-1:0]            csr_data   = '0;

   int                           mismatch_total;
   int                           beats_pending;
   int unsigned                  cycle_count = 0;
   int                           burst_left  = 0;
   int unsigned                  bytes_sent  = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   fixed_length_checksum_framer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   fcf_checker framer_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_total (mismatch_total),
      .beats_pending  (beats_pending)
   );

   // Hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached", $time);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: changing stall patterns, plus one long hold-off to back the block up
   initial begin : rsp_sink
      sink_mode_type mode;
      int            left;
      int            taken;
      int unsigned   tick;
      bit            held;
      mode  = SINK_OPEN;
      left  = 0;
      taken = 0;
      tick  = 0;
      held  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) taken++;
         // start the hold-off while the sender is offering bytes
         if (!held && taken >= HOLD_AFTER && req_tvalid) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (left == 0) begin
            mode = sink_mode_type'($urandom_range(0, 3));
            left = $urandom_range(32, 256);
         end
         left--;
         tick++;
         case (mode)
            SINK_OPEN:     rsp_tready <= 1'b1;
            SINK_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
            SINK_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
            SINK_PERIODIC: rsp_tready <= ((tick % 7) >= 3);
            default:       rsp_tready <= 1'b1;
         endcase
      end
   end

   function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] size);
      if (size < MIN_PACKET) return MIN_PACKET;
      if (size > MAX_PACKET_DEF) return MAX_PACKET_DEF;
      return size;
   endfunction

   // Byte values leaning on the extremes
   function automatic logic [BYTE_BITS-1:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic stream_kind_type pick_kind();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 14) return GOOD_FRAME;
      if (r < 17) return BAD_FRAME;
      return NOISE_RUN;
   endfunction

   // One byte request; bursts of random length separated by random gaps
   task automatic send_rx_byte(input logic [BYTE_BITS-1:0] rx);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      bytes_sent++;
   endtask

   // Payload followed by its big-endian sum; corrupt flips one check bit
   task automatic send_frame(input logic [BYTE_BITS-1:0] payload[$], input bit corrupt);
      logic [SUM_W-1:0] check;
      check = '0;
      foreach (payload[i]) begin
         check = check + payload[i];
         send_rx_byte(payload[i]);
      end
      if (corrupt) check = check ^ (16'h0001 << $urandom_range(0, SUM_W - 1));
      send_rx_byte(check[SUM_W-1:BYTE_BITS]);
      send_rx_byte(check[BYTE_BITS-1:0]);
   endtask

   // Stop offering, wait for every expected beat, then let a scan run out
   task automatic settle_framer();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (beats_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_packet_size(input logic [SIZE_W-1:0] size);
      csr_valid <= 1'b1;
      csr_data  <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [BYTE_BITS-1:0] frame[$];
      logic [SIZE_W-1:0]    sizes[$];
      int unsigned          eff;
      int unsigned          budget;
      int unsigned          start;
      bit                   paused;
      stream_kind_type      kind;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset size of 16: all-ones and all-zeros payload
      frame.delete();
      repeat (7) frame.push_back(8'hFF);
      repeat (7) frame.push_back(8'h00);
      send_frame(frame, 1'b0);

      // Size below range acts as the minimum packet
      settle_framer();
      write_packet_size(7'd1);
      frame = '{8'hFF};
      send_frame(frame, 1'b0);
      frame = '{8'h00};
      send_frame(frame, 1'b0);
      // stray byte in front: one miss, then a hit
      send_rx_byte(8'h5A);
      frame = '{8'hA5};
      send_frame(frame, 1'b0);

      // Random phases; extremes included, large sizes kept short
      sizes = '{7'd0, 7'd5, 7'd127, 7'd2, 7'd9, 7'd64, 7'd4, 7'd16, 7'd40, 7'd3, 7'd12};
      sizes[8] = 7'($urandom_range(17, 63));
      foreach (sizes[p]) begin
         settle_framer();
         write_packet_size(sizes[p]);
         eff    = clamp_size(sizes[p]);
         budget = (eff >= 32) ? eff + 12 : 40;
         start  = bytes_sent;
         paused = 1'b0;
         while (bytes_sent - start < budget) begin
            // one mid-phase drain with the window possibly half full
            if (p == 4 && !paused && bytes_sent - start >= budget / 2) begin
               settle_framer();
               paused = 1'b1;
            end
            kind = pick_kind();
            if (kind == NOISE_RUN) begin
               repeat ($urandom_range(1, eff)) send_rx_byte(pick_byte());
            end else begin
               frame.delete();
               repeat (eff - CHECK_BYTES) frame.push_back(pick_byte());
               send_frame(frame, kind == BAD_FRAME);
            end
         end
      end

      settle_framer();
      if (beats_pending != 0)
         $display("%0t: %0d expected responses never arrived", $time, beats_pending);
      if (mismatch_total == 0 && beats_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
